// ===== rtl/osc_single_argument_message_parser_defines.svh =====
// Assertion macros shared by the OSC message parser modules.
`ifndef OSC_SINGLE_ARGUMENT_MESSAGE_PARSER_DEFINES_SVH
`define OSC_SINGLE_ARGUMENT_MESSAGE_PARSER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define OSAP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define OSAP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/osap_pkg.sv =====
// Shared types, codes and tag decode for the OSC message parser.
package osap_pkg;

   localparam int PATH_MAX_DEFAULT   = 256;
   localparam int STRING_MAX_DEFAULT = 256;

   // Result kinds
   localparam logic [1:0] KIND_PATH_CHAR   = 2'd0;
   localparam logic [1:0] KIND_STRING_CHAR = 2'd1;
   localparam logic [1:0] KIND_SUMMARY     = 2'd2;

   // Argument types
   localparam logic [2:0] ARG_NONE  = 3'd0;
   localparam logic [2:0] ARG_INT   = 3'd1;
   localparam logic [2:0] ARG_FLOAT = 3'd2;
   localparam logic [2:0] ARG_STR   = 3'd3;
   localparam logic [2:0] ARG_TRUE  = 3'd4;
   localparam logic [2:0] ARG_FALSE = 3'd5;

   // Type tag characters
   localparam logic [7:0] TAG_INT   = 8'h69; // 'i'
   localparam logic [7:0] TAG_FLOAT = 8'h66; // 'f'
   localparam logic [7:0] TAG_STR   = 8'h73; // 's'
   localparam logic [7:0] TAG_TRUE  = 8'h54; // 'T'
   localparam logic [7:0] TAG_FALSE = 8'h46; // 'F'

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  char_byte;
      logic [2:0]  arg_type;
      logic [31:0] arg_value;
      logic        truncated;
      logic        last;
   } rsp_type;

   // Up to two results produced by one accepted byte, first in order first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [2:0] decode_tag(input logic [7:0] c);
      logic [2:0] code;
      case (c)
         TAG_INT:   code = ARG_INT;
         TAG_FLOAT: code = ARG_FLOAT;
         TAG_STR:   code = ARG_STR;
         TAG_TRUE:  code = ARG_TRUE;
         TAG_FALSE: code = ARG_FALSE;
         default:   code = ARG_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/osap_core.sv =====
// Byte-level parse state and result generation for the OSC message parser.
`include "osc_single_argument_message_parser_defines.svh"

module osap_core #(
   parameter int PATH_MAX   = 256,
   parameter int STRING_MAX = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_message,
   output osap_pkg::push_type push
);
   import osap_pkg::*;

   localparam int PATH_CW = $clog2(PATH_MAX);
   localparam int STR_CW  = $clog2(STRING_MAX);
   localparam logic [PATH_CW-1:0] PATH_LIMIT = PATH_CW'(PATH_MAX - 1);
   localparam logic [STR_CW-1:0]  STR_LIMIT  = STR_CW'(STRING_MAX - 1);

   typedef enum logic [2:0] {
      PH_PATH, PH_PATH_PAD, PH_TAG, PH_TAG_PAD, PH_VALUE, PH_STRING, PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in, arg_phase;
   logic [1:0]         offset_ff, offset_in;
   logic [PATH_CW-1:0] path_count_ff, path_count_in;
   logic [1:0]         tag_index_ff, tag_index_in;
   logic [2:0]         type_code_ff, type_code_in;
   logic [31:0]        value_ff, value_in;
   logic [2:0]         value_count_ff, value_count_in;
   logic [STR_CW-1:0]  str_count_ff, str_count_in;

   logic    aligned;
   logic    char_vld;
   logic    done;
   rsp_type char_rsp, sum_rsp;

   always_comb begin
      if (type_code_ff == ARG_INT || type_code_ff == ARG_FLOAT) begin
         arg_phase = PH_VALUE;
      end else if (type_code_ff == ARG_STR) begin
         arg_phase = PH_STRING;
      end else begin
         arg_phase = PH_DONE;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      offset_in      = offset_ff + 2'd1;
      path_count_in  = path_count_ff;
      tag_index_in   = tag_index_ff;
      type_code_in   = type_code_ff;
      value_in       = value_ff;
      value_count_in = value_count_ff;
      str_count_in   = str_count_ff;
      aligned        = (offset_in == 2'd0);
      char_vld       = 1'b0;
      char_rsp       = '0;
      char_rsp.char_byte = data_byte;

      case (phase_ff)
         PH_PATH: begin
            if (data_byte == 8'd0) begin
               phase_in = aligned ? PH_TAG : PH_PATH_PAD;
            end else if (path_count_ff < PATH_LIMIT) begin
               path_count_in = path_count_ff + 1'b1;
               char_vld      = 1'b1;
               char_rsp.kind = KIND_PATH_CHAR;
            end
         end
         PH_PATH_PAD: begin
            if (aligned) phase_in = PH_TAG;
         end
         PH_TAG: begin
            if (data_byte == 8'd0) begin
               if (arg_phase == PH_DONE) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = aligned ? arg_phase : PH_TAG_PAD;
               end
            end else begin
               if (tag_index_ff == 2'd1) type_code_in = decode_tag(data_byte);
               if (tag_index_ff < 2'd2) tag_index_in = tag_index_ff + 2'd1;
            end
         end
         PH_TAG_PAD: begin
            if (aligned) phase_in = arg_phase;
         end
         PH_VALUE: begin
            value_in       = {value_ff[23:0], data_byte};
            value_count_in = value_count_ff + 3'd1;
            if (value_count_in >= 3'd4) phase_in = PH_DONE;
         end
         PH_STRING: begin
            if (data_byte == 8'd0) begin
               phase_in = PH_DONE;
            end else if (str_count_ff < STR_LIMIT) begin
               str_count_in  = str_count_ff + 1'b1;
               char_vld      = 1'b1;
               char_rsp.kind = KIND_STRING_CHAR;
            end
         end
         default: begin
         end
      endcase

      // Summary sees the state after this byte.
      done                = (phase_in == PH_DONE);
      sum_rsp             = '0;
      sum_rsp.kind        = KIND_SUMMARY;
      sum_rsp.arg_type    = type_code_in;
      sum_rsp.arg_value   = (done && (type_code_in == ARG_INT || type_code_in == ARG_FLOAT))
                            ? value_in : 32'd0;
      sum_rsp.truncated   = !done;
      sum_rsp.last        = 1'b1;

      if (end_of_message) begin
         phase_in       = PH_PATH;
         offset_in      = '0;
         path_count_in  = '0;
         tag_index_in   = '0;
         type_code_in   = ARG_NONE;
         value_in       = '0;
         value_count_in = '0;
         str_count_in   = '0;
      end

      push.count  = accept ? ({1'b0, char_vld} + {1'b0, end_of_message}) : 2'd0;
      push.first  = char_vld ? char_rsp : sum_rsp;
      push.second = sum_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PATH;
         offset_ff      <= '0;
         path_count_ff  <= '0;
         tag_index_ff   <= '0;
         type_code_ff   <= ARG_NONE;
         value_ff       <= '0;
         value_count_ff <= '0;
         str_count_ff   <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         offset_ff      <= offset_in;
         path_count_ff  <= path_count_in;
         tag_index_ff   <= tag_index_in;
         type_code_ff   <= type_code_in;
         value_ff       <= value_in;
         value_count_ff <= value_count_in;
         str_count_ff   <= str_count_in;
      end
   end

   `OSAP_ASSERT(a_eom_restarts,
      (accept && end_of_message) |=> (phase_ff == PH_PATH && offset_ff == 2'd0 && tag_index_ff == 2'd0),
      "parse state not restarted after end of message")
   `OSAP_ASSERT(a_pair_order,
      (push.count == 2'd2) |-> (push.second.last && !push.first.last),
      "character and summary out of order")
   `OSAP_ASSERT(a_push_needs_accept,
      !accept |-> (push.count == 2'd0),
      "result pushed without an accepted transaction")

endmodule

// ===== rtl/osap_rsp_queue.sv =====
// Three-slot result buffer; slot zero is the output register.
`include "osc_single_argument_message_parser_defines.svh"

module osap_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  osap_pkg::push_type push,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output osap_pkg::rsp_type  rsp_head,
   output logic               req_stall
);
   import osap_pkg::*;

   rsp_type    q_ff [3];
   rsp_type    q_in [3];
   rsp_type    shifted [3];
   logic [1:0] count_ff, count_in, count_after;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_head  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   // Room for two results is needed before a byte is taken.
   assign req_stall = count_ff[1];

   always_comb begin
      shifted[0]  = pop ? q_ff[1] : q_ff[0];
      shifted[1]  = pop ? q_ff[2] : q_ff[1];
      shifted[2]  = q_ff[2];
      count_after = count_ff - {1'b0, pop};
      count_in    = count_after + push.count;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < count_after) begin
            q_in[i] = shifted[i];
         end else if (2'(i) == count_after) begin
            q_in[i] = push.first;
         end else begin
            q_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `OSAP_ASSERT(a_no_overflow,
      (push.count != 2'd0) |-> (count_ff <= 2'd1),
      "push into a queue without room")
   `OSAP_ASSERT(a_shift_order,
      (count_ff == 2'd2 && pop && push.count == 2'd0) |=> (q_ff[0] == $past(q_ff[1])),
      "queue lost order on pop")
   `OSAP_ASSERT_ALWAYS(a_reset_empty,
      reset |=> !rsp_valid,
      "results pending after reset")

endmodule

// ===== rtl/osc_single_argument_message_parser.sv =====
// Top level of the single-argument OSC message parser.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  data_byte, end_of_message
//   rsp_      out        rsp_valid/rsp_stall  kind, char_byte, arg_type, arg_value,
//                                             truncated, last
//
// One byte is parsed per accepted cycle: the parse state updates in the
// accepting cycle, and its results are registered in a three-slot buffer
// whose first slot drives the rsp_ ports. A byte may yield two results
// (a character and the closing summary); the buffer drains one per
// unstalled cycle, so req_stall rises while two or more wait. Reset is
// synchronous: it clears the parse state and empties the buffer. rsp_stall
// only holds the buffer; parsing continues while room remains.
module osc_single_argument_message_parser #(
   parameter int PATH_MAX   = osap_pkg::PATH_MAX_DEFAULT,
   parameter int STRING_MAX = osap_pkg::STRING_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_char_byte,
   output logic [2:0]  rsp_arg_type,
   output logic [31:0] rsp_arg_value,
   output logic        rsp_truncated,
   output logic        rsp_last
);
   import osap_pkg::*;

   logic     accept;
   push_type push;
   rsp_type  head;

   assign accept = req_valid && !req_stall;

   // Path / tag / argument tracking, one byte per accepted transaction.
   osap_core #(
      .PATH_MAX   (PATH_MAX),
      .STRING_MAX (STRING_MAX)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .push           (push)
   );

   // Result buffer, also provides the input back-pressure.
   osap_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_head  (head),
      .req_stall (req_stall)
   );

   assign rsp_kind      = head.kind;
   assign rsp_char_byte = head.char_byte;
   assign rsp_arg_type  = head.arg_type;
   assign rsp_arg_value = head.arg_value;
   assign rsp_truncated = head.truncated;
   assign rsp_last      = head.last;

endmodule
